// ===== rtl/rsmp_pkg.sv =====
// Shared constants and types of the peak/interpolate resampler.
// No dependencies; imported by every module of the block.
package rsmp_pkg;

	localparam int LEN_W           = 16;
	localparam int FRAC_W          = 16;
	localparam int CFG_IDX_W       = 8;
	localparam int DIV_NW          = 2 * LEN_W + 1;
	localparam int DIV_DW          = LEN_W + 1;
	localparam int QUEUE_DEPTH     = 2;

	localparam int DEF_SAMPLE_BITS = 24;
	localparam int DEF_MAX_BURST   = 64;
	localparam int DEF_MAX_FRAME   = 65535;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LENGTH = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_LENGTH   = 8'd1;
	localparam logic [LEN_W-1:0]     RST_LENGTH        = 16'd1024;

	typedef struct packed {
		logic ok;
		logic zero;
	} smp_flags_t;

endpackage

// ===== rtl/rsmp_front.sv =====
// Input side: takes sample beats, tags them valid/zero and queues them.
// Depends on rsmp_pkg.
module rsmp_front #(
	parameter int SAMPLE_BITS = rsmp_pkg::DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          sample_valid,
	output logic                          q_valid,
	input  logic                          q_pop,
	output logic signed [SAMPLE_BITS-1:0] q_value,
	output rsmp_pkg::smp_flags_t          q_flags
);
	import rsmp_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic signed [SAMPLE_BITS-1:0] val_q [QUEUE_DEPTH];
	smp_flags_t                    flg_q [QUEUE_DEPTH];
	logic [PW-1:0]                 wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]                 count_q;
	logic                          push, pop;
	smp_flags_t                    in_flags;

	assign in_stall      = (count_q == CW'(QUEUE_DEPTH));
	assign q_valid       = (count_q != '0);
	assign push          = in_valid && !in_stall;
	assign pop           = q_pop && q_valid;
	assign q_value       = val_q[rd_ptr_q];
	assign q_flags       = flg_q[rd_ptr_q];
	assign in_flags.ok   = sample_valid;
	assign in_flags.zero = (sample == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			val_q[wr_ptr_q] <= sample;
			flg_q[wr_ptr_q] <= in_flags;
		end
	end

endmodule

// ===== rtl/rsmp_div.sv =====
// Restoring divider, one quotient bit per cycle, for window ends and fractions.
// Depends on rsmp_pkg.
module rsmp_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rsmp_pkg::DIV_NW-1:0] numer,
	input  logic [rsmp_pkg::DIV_DW-1:0] denom,
	output logic                        done,
	output logic [rsmp_pkg::DIV_NW-1:0] quot
);
	import rsmp_pkg::*;

	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, done_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] rem_q, den_q, rem_nxt;
	logic [DIV_DW:0]   trial;
	logic              qbit;

	always_comb begin
		trial   = {rem_q, quo_q[DIV_NW-1]};
		qbit    = (trial >= {1'b0, den_q});
		rem_nxt = qbit ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
	end

	assign done = done_q;
	assign quot = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(DIV_NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NW-2:0], qbit};
			rem_q <= rem_nxt;
		end
	end

endmodule

// ===== rtl/rsmp_back.sv =====
// Back end: frame state, min/max windows, linear blend and result sequencing.
// Depends on rsmp_pkg and rsmp_div.
module rsmp_back #(
	parameter int SAMPLE_BITS = rsmp_pkg::DEF_SAMPLE_BITS,
	parameter int MAX_BURST   = rsmp_pkg::DEF_MAX_BURST,
	parameter int MAX_FRAME   = rsmp_pkg::DEF_MAX_FRAME
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rsmp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rsmp_pkg::LEN_W-1:0]     cfg_data,
	input  logic                           q_valid,
	output logic                           q_pop,
	input  logic signed [SAMPLE_BITS-1:0]  q_value,
	input  rsmp_pkg::smp_flags_t           q_flags,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic signed [SAMPLE_BITS-1:0]  out_value,
	output logic                           out_valid,
	output logic                           last_of_run,
	output logic                           frame_done,
	output logic                           overflow
);
	import rsmp_pkg::*;

	localparam int SB   = SAMPLE_BITS;
	localparam int BW   = $clog2(MAX_BURST + 1);
	localparam int PW   = SB + FRAC_W + 2;
	localparam int SUMW = PW + 1;
	localparam logic signed [SUMW-1:0] HALF = SUMW'(1) << (FRAC_W - 1);

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_INIT  = 14'b00000000000010,
		S_DEC   = 14'b00000000000100,
		S_PAIR0 = 14'b00000000001000,
		S_PAIR1 = 14'b00000000010000,
		S_DECW  = 14'b00000000100000,
		S_INTA  = 14'b00000001000000,
		S_INTB  = 14'b00000010000000,
		S_ICALC = 14'b00000100000000,
		S_IDIV  = 14'b00001000000000,
		S_IMUL  = 14'b00010000000000,
		S_ISUM  = 14'b00100000000000,
		S_IPUT  = 14'b01000000000000,
		S_FLUSH = 14'b10000000000000
	} state_t;

	state_t              state_q;
	logic                need_init_q;
	logic [LEN_W-1:0]    src_len_q, dst_len_q;
	logic [LEN_W-1:0]    in_count_q, oc_q, wep_q, rem_q, first_end_q;
	logic [LEN_W-1:0]    min_pos_q, max_pos_q;
	logic [1:0]          flags_q;
	logic signed [SB-1:0] run_min_q, run_max_q, prev_q;
	logic                prev_ok_q, prev_zero_q;
	logic [BW-1:0]       res_n_q;
	logic                drop_q, pending_q, phase_b_q, hold_v_q, o_vld_q;

	logic signed [SB-1:0] cur_q, a_q, b_q, res_val_q, hold_val_q, o_val_q;
	logic                cur_ok_q, cur_zero_q, aok_q, bok_q, azero_q, bzero_q;
	logic                res_ok_q, hold_ok_q, o_ok_q, o_last_q, o_fin_q, o_ovf_q;
	logic [FRAC_W-1:0]   frac_q;
	logic signed [PW-1:0] prod_q;

	logic [LEN_W-1:0]    s_eff, d_eff, total, s_m1, q_end;
	logic                dec_mode, out_free, full_burst, put_ready, do_put, out_load;
	logic                bad_win, min_first, blend, fin, room_dec, room_int;
	logic signed [SB-1:0] first_v, second_v, put_val;
	logic                put_ok;
	logic [LEN_W:0]      di_p2;
	logic [2*LEN_W:0]    prod_dec;
	logic                div_start, div_done;
	logic [DIV_NW-1:0]   div_numer, div_quot;
	logic [DIV_DW-1:0]   div_denom;
	logic signed [SB:0]  diff_c;
	logic signed [FRAC_W:0] frac_s;
	logic signed [PW-1:0] prod_c;
	logic signed [SUMW-1:0] a_ext, p_ext, sum_c;
	logic                cfg_we;

	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
		logic [LEN_W-1:0] r;
		r = (v == '0) ? LEN_W'(1) : v;
		if (int'(r) > MAX_FRAME) begin
			r = LEN_W'(MAX_FRAME);
		end
		return r;
	endfunction

	assign s_eff      = eff_len(src_len_q);
	assign d_eff      = eff_len(dst_len_q);
	assign s_m1       = s_eff - 1'b1;
	assign dec_mode   = (s_eff > d_eff);
	assign total      = dec_mode ? {d_eff[LEN_W-1:1], 1'b0} : d_eff;
	assign room_dec   = ({1'b0, oc_q} + 1'b1 + 1'b1) <= {1'b0, d_eff};
	assign room_int   = (oc_q < d_eff);
	assign out_free   = !o_vld_q || !res_stall;
	assign full_burst = (res_n_q >= BW'(MAX_BURST));
	assign put_ready  = full_burst || !hold_v_q || out_free;
	assign fin        = pending_q && (oc_q >= total);
	assign cfg_ready  = 1'b1;
	assign cfg_we     = cfg_valid && cfg_ready;
	assign q_pop      = (state_q == S_IDLE) && !need_init_q && q_valid;

	assign bad_win   = (flags_q != 2'b01);
	assign min_first = !(min_pos_q > max_pos_q);
	assign first_v   = bad_win ? '0 : (min_first ? run_min_q : run_max_q);
	assign second_v  = bad_win ? '0 : (min_first ? run_max_q : run_min_q);
	assign blend     = bok_q && aok_q && phase_b_q == 1'b0 && !azero_q && !bzero_q;

	// window end: round((i+2)*S/D) = (2*(i+2)*S + D) / (2*D)
	assign di_p2     = (state_q == S_IDLE) ? (LEN_W+1)'(2) : ({1'b0, oc_q} + (LEN_W+1)'(4));
	assign prod_dec  = di_p2 * s_eff;
	assign q_end     = (div_quot > DIV_NW'(s_m1)) ? s_m1 : div_quot[LEN_W-1:0];

	always_comb begin
		div_start = 1'b0;
		div_numer = DIV_NW'({prod_dec, 1'b0}) + DIV_NW'(d_eff);
		div_denom = {d_eff, 1'b0};
		case (state_q)
			S_IDLE: begin
				div_start = need_init_q && dec_mode && !cfg_we;
			end
			S_PAIR1: begin
				div_start = do_put;
			end
			S_ICALC: begin
				div_start = blend;
				div_numer = DIV_NW'({rem_q, {FRAC_W{1'b0}}});
				div_denom = DIV_DW'(d_eff);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		do_put  = 1'b0;
		put_val = '0;
		put_ok  = 1'b0;
		case (state_q)
			S_PAIR0: begin
				do_put  = put_ready;
				put_val = first_v;
				put_ok  = !bad_win;
			end
			S_PAIR1: begin
				do_put  = put_ready;
				put_val = second_v;
				put_ok  = !bad_win;
			end
			S_IPUT: begin
				do_put  = put_ready;
				put_val = res_val_q;
				put_ok  = res_ok_q;
			end
			default: begin
			end
		endcase
	end

	assign out_load = (do_put && !full_burst && hold_v_q) ||
	                  (state_q == S_FLUSH && hold_v_q && out_free);

	// blend: a + (b - a) * frac, rounded half up
	assign diff_c = {b_q[SB-1], b_q} - {a_q[SB-1], a_q};
	assign frac_s = {1'b0, frac_q};
	assign prod_c = diff_c * frac_s;
	assign a_ext  = {{(SUMW-SB-FRAC_W){a_q[SB-1]}}, a_q, {FRAC_W{1'b0}}};
	assign p_ext  = {prod_q[PW-1], prod_q};
	assign sum_c  = a_ext + p_ext + HALF;

	rsmp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_numer),
		.denom  (div_denom),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			need_init_q <= 1'b1;
			src_len_q   <= RST_LENGTH;
			dst_len_q   <= RST_LENGTH;
			in_count_q  <= '0;
			oc_q        <= '0;
			wep_q       <= '0;
			rem_q       <= '0;
			first_end_q <= '0;
			min_pos_q   <= '0;
			max_pos_q   <= '0;
			flags_q     <= '0;
			run_min_q   <= '0;
			run_max_q   <= '0;
			prev_q      <= '0;
			prev_ok_q   <= 1'b0;
			prev_zero_q <= 1'b1;
			res_n_q     <= '0;
			drop_q      <= 1'b0;
			pending_q   <= 1'b0;
			phase_b_q   <= 1'b0;
			hold_v_q    <= 1'b0;
			o_vld_q     <= 1'b0;
		end else begin
			if (out_load) begin
				o_vld_q <= 1'b1;
			end else if (!res_stall) begin
				o_vld_q <= 1'b0;
			end
			if (do_put) begin
				if (full_burst) begin
					drop_q <= 1'b1;
				end else begin
					hold_v_q <= 1'b1;
					res_n_q  <= res_n_q + 1'b1;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (need_init_q && !cfg_we) begin
						if (dec_mode) begin
							state_q <= S_INIT;
						end else begin
							wep_q       <= '0;
							first_end_q <= '0;
							need_init_q <= 1'b0;
						end
					end else if (q_pop) begin
						res_n_q   <= '0;
						drop_q    <= 1'b0;
						pending_q <= (oc_q < total);
						if (dec_mode) begin
							state_q <= S_DEC;
							if (room_dec && in_count_q < wep_q) begin
								if (!q_flags.ok) begin
									flags_q[1] <= 1'b1;
								end else if (!flags_q[0]) begin
									run_min_q  <= q_value;
									run_max_q  <= q_value;
									min_pos_q  <= in_count_q;
									max_pos_q  <= in_count_q;
									flags_q[0] <= 1'b1;
								end else begin
									if (q_value < run_min_q) begin
										run_min_q <= q_value;
										min_pos_q <= in_count_q;
									end
									if (q_value > run_max_q) begin
										run_max_q <= q_value;
										max_pos_q <= in_count_q;
									end
								end
							end
						end else begin
							state_q <= S_INTA;
						end
					end
				end
				S_INIT: begin
					if (div_done) begin
						wep_q       <= q_end;
						first_end_q <= q_end;
						need_init_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				S_DEC: begin
					if (room_dec && ({1'b0, wep_q} <= ({1'b0, in_count_q} + 1'b1))) begin
						state_q <= S_PAIR0;
					end else begin
						state_q <= S_FLUSH;
					end
				end
				S_PAIR0: begin
					if (do_put) begin
						state_q <= S_PAIR1;
					end
				end
				S_PAIR1: begin
					if (do_put) begin
						oc_q    <= oc_q + LEN_W'(2);
						flags_q <= '0;
						state_q <= S_DECW;
					end
				end
				S_DECW: begin
					if (div_done) begin
						wep_q   <= q_end;
						state_q <= S_DEC;
					end
				end
				S_INTA: begin
					if (in_count_q != '0 && room_int && wep_q == in_count_q - 1'b1) begin
						phase_b_q <= 1'b0;
						state_q   <= S_ICALC;
					end else begin
						state_q <= S_INTB;
					end
				end
				S_INTB: begin
					if (in_count_q == s_m1 && room_int && wep_q == in_count_q) begin
						phase_b_q <= 1'b1;
						state_q   <= S_ICALC;
					end else begin
						prev_q      <= cur_q;
						prev_ok_q   <= cur_ok_q;
						prev_zero_q <= cur_zero_q;
						state_q     <= S_FLUSH;
					end
				end
				S_ICALC: begin
					state_q <= blend ? S_IDIV : S_IPUT;
				end
				S_IDIV: begin
					if (div_done) begin
						state_q <= S_IMUL;
					end
				end
				S_IMUL: begin
					state_q <= S_ISUM;
				end
				S_ISUM: begin
					state_q <= S_IPUT;
				end
				S_IPUT: begin
					if (do_put) begin
						oc_q <= oc_q + 1'b1;
						if (({1'b0, rem_q} + {1'b0, s_eff}) >= {1'b0, d_eff}) begin
							rem_q <= LEN_W'({1'b0, rem_q} + {1'b0, s_eff} - {1'b0, d_eff});
							wep_q <= wep_q + 1'b1;
						end else begin
							rem_q <= rem_q + s_eff;
						end
						state_q <= phase_b_q ? S_INTB : S_INTA;
					end
				end
				S_FLUSH: begin
					if (!hold_v_q || out_free) begin
						hold_v_q <= 1'b0;
						state_q  <= S_IDLE;
						if (({1'b0, in_count_q} + 1'b1) >= {1'b0, s_eff}) begin
							in_count_q  <= '0;
							oc_q        <= '0;
							rem_q       <= '0;
							wep_q       <= first_end_q;
							min_pos_q   <= '0;
							max_pos_q   <= '0;
							flags_q     <= '0;
							run_min_q   <= '0;
							run_max_q   <= '0;
							prev_q      <= '0;
							prev_ok_q   <= 1'b0;
							prev_zero_q <= 1'b1;
						end else begin
							in_count_q <= in_count_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_we && (cfg_index == REG_SOURCE_LENGTH || cfg_index == REG_DEST_LENGTH)) begin
				if (cfg_index == REG_SOURCE_LENGTH) begin
					src_len_q <= cfg_data;
				end else begin
					dst_len_q <= cfg_data;
				end
				// a window-end division already running is stale; start over
				state_q     <= S_IDLE;
				need_init_q <= 1'b1;
				in_count_q  <= '0;
				oc_q        <= '0;
				rem_q       <= '0;
				wep_q       <= '0;
				min_pos_q   <= '0;
				max_pos_q   <= '0;
				flags_q     <= '0;
				run_min_q   <= '0;
				run_max_q   <= '0;
				prev_q      <= '0;
				prev_ok_q   <= 1'b0;
				prev_zero_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q      <= q_value;
			cur_ok_q   <= q_flags.ok;
			cur_zero_q <= q_flags.zero;
		end
		if (state_q == S_INTA) begin
			a_q     <= prev_q;
			aok_q   <= prev_ok_q;
			azero_q <= prev_zero_q;
			b_q     <= cur_q;
			bok_q   <= cur_ok_q;
			bzero_q <= cur_zero_q;
		end else if (state_q == S_INTB) begin
			a_q     <= cur_q;
			aok_q   <= cur_ok_q;
			azero_q <= cur_zero_q;
		end
		if (state_q == S_ICALC) begin
			if (phase_b_q) begin
				res_val_q <= aok_q ? a_q : '0;
				res_ok_q  <= aok_q;
			end else if (!aok_q || !bok_q) begin
				res_val_q <= '0;
				res_ok_q  <= 1'b0;
			end else if (azero_q) begin
				res_val_q <= b_q;
				res_ok_q  <= 1'b1;
			end else begin
				res_val_q <= a_q;
				res_ok_q  <= 1'b1;
			end
		end
		if (state_q == S_IDIV && div_done) begin
			frac_q <= div_quot[FRAC_W-1:0];
		end
		if (state_q == S_IMUL) begin
			prod_q <= prod_c;
		end
		if (state_q == S_ISUM) begin
			res_val_q <= sum_c[FRAC_W+SB-1:FRAC_W];
			res_ok_q  <= 1'b1;
		end
		if (do_put && !full_burst) begin
			hold_val_q <= put_val;
			hold_ok_q  <= put_ok;
		end
		if (out_load) begin
			o_val_q  <= hold_val_q;
			o_ok_q   <= hold_ok_q;
			o_last_q <= (state_q == S_FLUSH);
			o_fin_q  <= (state_q == S_FLUSH) && fin;
			o_ovf_q  <= (state_q == S_FLUSH) && drop_q;
		end
	end

	assign res_valid   = o_vld_q;
	assign out_value   = o_val_q;
	assign out_valid   = o_ok_q;
	assign last_of_run = o_last_q;
	assign frame_done  = o_fin_q;
	assign overflow    = o_ovf_q;

endmodule

// ===== rtl/peak_decimate_or_interpolate_resampler_unit.sv =====
// Top level of the peak-decimating / linearly interpolating frame resampler.
// Depends on rsmp_pkg, rsmp_front, rsmp_back (which holds rsmp_div).
//
// Usage:
//   Input channel (in_valid/in_stall) takes one sample beat per source sample;
//   a two-entry queue lets the sender run ahead of the engine.
//   Result channel (res_valid/res_stall) gives the resampled beats; the last
//   beat caused by a sample has last_of_run set, with frame_done and overflow.
//   Config channel (cfg_valid/cfg_ready) writes source_length (index 0) and
//   dest_length (index 1); any such write restarts the frame.
// Sequencing:
//   The engine pops the next sample only when back in idle, after its
//   outputs. In decimation a pair is bound by the window-end divider. In
//   interpolation a blended output runs the fraction divider, multiply and
//   add; pass-through outputs skip them. The first sample after reset
//   or a config write in decimation waits for the first window end.
// Reset and stall:
//   arst_n clears queue and frame state; both lengths return to 1024. While
//   res_stall is high one result waits in the output register and one more in
//   the hold stage, then the engine stops; the queue takes samples until full.
module peak_decimate_or_interpolate_resampler_unit #(
	parameter int SAMPLE_BITS = rsmp_pkg::DEF_SAMPLE_BITS,
	parameter int MAX_BURST   = rsmp_pkg::DEF_MAX_BURST,
	parameter int MAX_FRAME   = rsmp_pkg::DEF_MAX_FRAME
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rsmp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rsmp_pkg::LEN_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_BITS-1:0]  sample,
	input  logic                           sample_valid,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic signed [SAMPLE_BITS-1:0]  out_value,
	output logic                           out_valid,
	output logic                           last_of_run,
	output logic                           frame_done,
	output logic                           overflow
);
	import rsmp_pkg::*;

	logic                    q_valid, q_pop;
	logic signed [SAMPLE_BITS-1:0] q_value;
	smp_flags_t              q_flags;

	rsmp_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.sample_valid (sample_valid),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_value      (q_value),
		.q_flags      (q_flags)
	);

	rsmp_back #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_BURST   (MAX_BURST),
		.MAX_FRAME   (MAX_FRAME)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_value     (q_value),
		.q_flags     (q_flags),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.out_value   (out_value),
		.out_valid   (out_valid),
		.last_of_run (last_of_run),
		.frame_done  (frame_done),
		.overflow    (overflow)
	);

	a_fin_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_done |-> last_of_run)
		else $error("frame_done on a beat that is not last of run");

	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && overflow |-> last_of_run)
		else $error("overflow on a beat that is not last of run");

	a_nan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> out_value == '0)
		else $error("invalid result with non-zero value");

endmodule

// ===== tb/peak_decimate_or_interpolate_resampler_unit_tb.sv =====
// Self-checking bench for the peak-decimating / interpolating resampler.
// Needs rsmp_pkg and the RTL of peak_decimate_or_interpolate_resampler_unit.
// Predicts each result beat per accepted sample; compares in order.
`timescale 1ns / 100ps

module peak_decimate_or_interpolate_resampler_unit_tb;
	import rsmp_pkg::*;

	localparam int SB       = 24;
	localparam int BURST    = 64;
	localparam int WD_LIMIT = 20000;
	localparam int SETTLE   = 200;

	typedef struct {
		logic [SB-1:0] smp;
		logic          ok;
	} smp_item_t;

	typedef struct {
		logic [SB-1:0] value;
		logic          ok;
		logic          last;
		logic          done;
		logic          ovf;
	} res_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SOURCE_LENGTH;
	logic [LEN_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic signed [SB-1:0] sample = '0;
	logic                 sample_valid = 1'b0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic signed [SB-1:0] out_value;
	logic                 out_valid;
	logic                 last_of_run;
	logic                 frame_done;
	logic                 overflow;

	peak_decimate_or_interpolate_resampler_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample),
		.sample_valid(sample_valid),
		.res_valid(res_valid), .res_stall(res_stall), .out_value(out_value),
		.out_valid(out_valid), .last_of_run(last_of_run), .frame_done(frame_done),
		.overflow(overflow)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	smp_item_t pend_samples[$];
	res_beat_t due_beats[$];
	res_beat_t burst[$];
	bit        burst_drop;
	int        errs = 0;
	int        send_idle = 0;
	int        recv_idle = 0;
	logic      took = 1'b0;
	int        quiet = 0;

	// resampler state as the predictor sees it
	int unsigned src_len = 1024, dst_len = 1024;
	int unsigned n_in, n_out, win_end, rem, lo_at, hi_at;
	longint    lo_v, hi_v, prev_v;
	bit [1:0]  wflags;
	bit        prev_ok;

	function automatic int unsigned eff(int unsigned v);
		return (v == 0) ? 1 : v;
	endfunction

	function automatic int unsigned win_bound(int unsigned i, int unsigned s, int unsigned d);
		longint unsigned e;
		e = (2 * (longint'(i) + 2) * s + d) / (2 * longint'(d));
		if (e > s - 1) e = s - 1;
		return int'(e);
	endfunction

	function automatic void restart_frame();
		int unsigned s, d;
		s = eff(src_len);
		d = eff(dst_len);
		n_in = 0; n_out = 0; rem = 0;
		lo_v = 0; hi_v = 0; lo_at = 0; hi_at = 0;
		wflags = 0; prev_v = 0; prev_ok = 0;
		win_end = (s > d) ? win_bound(0, s, d) : 0;
	endfunction

	function automatic void emit(longint v, bit ok);
		res_beat_t b;
		if (burst.size() >= BURST) begin
			burst_drop = 1;
			return;
		end
		b.value = ok ? v[SB-1:0] : '0;
		b.ok = ok; b.last = 0; b.done = 0; b.ovf = 0;
		burst = {burst, b};
	endfunction

	function automatic void close_pair(int unsigned s, int unsigned d);
		if (wflags != 2'b01) begin
			emit(0, 0); emit(0, 0);
		end else if (lo_at > hi_at) begin
			emit(hi_v, 1); emit(lo_v, 1);
		end else begin
			emit(lo_v, 1); emit(hi_v, 1);
		end
		n_out += 2;
		wflags = 0;
		win_end = win_bound(n_out, s, d);
	endfunction

	function automatic void lerp_out(longint a, bit aok, longint b, bit bok, bit has_b,
			int unsigned s, int unsigned d);
		longint frac, t;
		frac = longint'((longint'(rem) << 16) / d);
		if (!has_b) emit(a, aok);
		else if (!aok || !bok) emit(0, 0);
		else if (a == 0 && b != 0) emit(b, 1);
		else if (a != 0 && b == 0) emit(a, 1);
		else begin
			t = a * (65536 - frac) + b * frac + 32768;
			emit(t >>> 16, 1);
		end
		n_out++;
		rem += s;
		if (rem >= d) begin
			rem -= d;
			win_end++;
		end
	endfunction

	function automatic void resample_step(logic [SB-1:0] raw, logic ok);
		int unsigned s, d, j, total;
		longint v;
		bit pending, fin;
		s = eff(src_len);
		d = eff(dst_len);
		j = n_in;
		v = longint'($signed(raw));
		burst.delete();
		burst_drop = 0;
		if (s > d) begin
			total = d & ~32'd1;
			pending = n_out < total;
			if (n_out + 2 <= d && j < win_end) begin
				if (!ok) wflags |= 2'b10;
				else if (!wflags[0]) begin
					lo_v = v; hi_v = v; lo_at = j; hi_at = j;
					wflags |= 2'b01;
				end else begin
					if (v < lo_v) begin lo_v = v; lo_at = j; end
					if (v > hi_v) begin hi_v = v; hi_at = j; end
				end
			end
			while (n_out + 2 <= d && win_end <= j + 1) close_pair(s, d);
		end else begin
			total = d;
			pending = n_out < total;
			if (j >= 1)
				while (n_out < d && win_end == j - 1) lerp_out(prev_v, prev_ok, v, ok, 1, s, d);
			if (j == s - 1)
				while (n_out < d && win_end == j) lerp_out(v, ok, 0, 0, 0, s, d);
			prev_v = v;
			prev_ok = ok;
		end
		fin = pending && n_out >= total;
		n_in = j + 1;
		if (n_in >= s) restart_frame();
		if (burst.size() > 0) begin
			burst[$].last = 1;
			burst[$].done = fin;
			burst[$].ovf = burst_drop;
		end
		due_beats = {due_beats, burst};
	endfunction

	// driver: new beat only once the previous one has gone
	always @(negedge clk) begin
		smp_item_t it;
		if (!in_valid || took) begin
			if (pend_samples.size() > 0 && $urandom_range(99) >= send_idle) begin
				it = pend_samples.pop_front();
				sample <= it.smp;
				sample_valid <= it.ok;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		res_stall <= ($urandom_range(99) < recv_idle);
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		res_beat_t e;
		bit moved;
		moved = 0;
		took <= in_valid && !in_stall && arst_n;
		if (arst_n && res_valid && !res_stall) begin
			moved = 1;
			if (due_beats.size() == 0) begin
				$error("result beat with nothing expected: value %0d", out_value);
				errs++;
			end else begin
				e = due_beats.pop_front();
				if (out_value !== e.value) begin
					$error("out_value: expected %0d, got %0d", $signed(e.value), out_value);
					errs++;
				end
				if (out_valid !== e.ok) begin
					$error("out_valid: expected %0b, got %0b", e.ok, out_valid);
					errs++;
				end
				if (last_of_run !== e.last) begin
					$error("last_of_run: expected %0b, got %0b", e.last, last_of_run);
					errs++;
				end
				if (frame_done !== e.done) begin
					$error("frame_done: expected %0b, got %0b", e.done, frame_done);
					errs++;
				end
				if (overflow !== e.ovf) begin
					$error("overflow: expected %0b, got %0b", e.ovf, overflow);
					errs++;
				end
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			moved = 1;
			resample_step(sample, sample_valid);
		end
		if (cfg_valid && cfg_ready) moved = 1;
		if (!arst_n || moved) quiet <= 0;
		else if (quiet + 1 >= WD_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else quiet <= quiet + 1;
	end

	task automatic add_sample(int v, int ok);
		smp_item_t it;
		it.smp = SB'(v);
		it.ok = (ok != 0);
		pend_samples = {pend_samples, it};
	endtask

	task automatic wait_quiet();
		while (pend_samples.size() > 0 || in_valid || due_beats.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_SOURCE_LENGTH) src_len = val;
		else dst_len = val;
		restart_frame();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_lengths(int unsigned s, int unsigned d);
		wait_quiet();
		write_reg(REG_SOURCE_LENGTH, s[LEN_W-1:0]);
		write_reg(REG_DEST_LENGTH, d[LEN_W-1:0]);
	endtask

	function automatic logic [SB-1:0] rand_sample();
		case ($urandom_range(9))
			0: return '0;
			1: return 24'h800000;
			2: return 24'h7FFFFF;
			3: return SB'($urandom_range(7) - 3);
			default: return SB'($urandom());
		endcase
	endfunction

	task automatic add_rand_frame(int unsigned n);
		repeat (n) add_sample(rand_sample(), $urandom_range(11) != 0);
	endtask

	initial begin
		int unsigned s, d, fed;
		restart_frame();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 13 : (ph == 1) ? 63 : 0;
			recv_idle = (ph == 0) ? 63 : (ph == 1) ? 13 : 0;
			if (ph == 0) begin
				// interpolation: extremes, zero neighbours
				set_lengths(4, 8);
				add_sample(24'h7FFFFF, 1); add_sample(24'h800000, 1);
				add_sample(24'h000000, 1); add_sample(24'h000123, 1);
				// decimation, odd final slot, ties, bad sample in a window
				set_lengths(8, 3);
				add_sample(5, 1); add_sample(5, 1); add_sample(-5, 1); add_sample(-5, 1);
				add_sample(9, 1); add_sample(3, 0); add_sample(1, 1); add_sample(2, 1);
				// zero length acts as one
				set_lengths(0, 0);
				add_sample(24'hABCDEF, 1); add_sample(24'h123456, 0);
				// burst overflow
				set_lengths(3, 200);
				add_sample(24'h400000, 1); add_sample(24'hC00000, 1); add_sample(7, 1);
				// longest lengths
				set_lengths(65535, 65535);
				add_sample(24'h7FFFFF, 1); add_sample(24'h800000, 1); add_sample(0, 1);
				set_lengths(65535, 2);
				add_sample(1, 1); add_sample(24'hFFFFFF, 1);
			end
			fed = 0;
			while (fed < 90) begin
				case ($urandom_range(3))
					0: begin s = $urandom_range(24, 2); d = $urandom_range(s - 1, 1); end
					1: begin d = $urandom_range(40, 2); s = $urandom_range(d, 1); end
					2: begin s = $urandom_range(12, 1); d = $urandom_range(12, 1); end
					default: begin s = $urandom_range(20, 3); d = s; end
				endcase
				set_lengths(s, d);
				repeat ($urandom_range(2, 1)) begin
					add_rand_frame(s);
					fed += s;
				end
				// an unfinished frame now and then
				if ($urandom_range(3) == 0) begin
					add_rand_frame(s / 2);
					fed += s / 2;
				end
			end
		end
		wait_quiet();
		if (errs == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rsmp_pkg.sv
rtl/rsmp_front.sv
rtl/rsmp_div.sv
rtl/rsmp_back.sv
rtl/peak_decimate_or_interpolate_resampler_unit.sv
tb/peak_decimate_or_interpolate_resampler_unit_tb.sv
